@@ rtl/hfla_pkg.sv @@
// Package for the hex-float long arithmetic unit: item types, operation codes,
// sequencer states. No dependencies.
`default_nettype none
package hfla_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MULR = 3'd2,
        OP_MULX = 3'd3,
        OP_DIV  = 3'd4,
        OP_CVT  = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [63:0]        operand_a;
        logic [63:0]        operand_b;
        logic signed [31:0] int_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic        divide_by_zero;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORMA,
        ST_NORMB,
        ST_ADDALIGN,
        ST_ADDOP,
        ST_ADDNORM,
        ST_ROUND,
        ST_MUL,
        ST_MULFIN,
        ST_DIV,
        ST_DIVFIN,
        ST_DONE
    } state_t;

    localparam int FracW   = 56;
    localparam int ShiftOut = 14;

endpackage
`default_nettype wire

@@ rtl/hfla_mul_step.sv @@
// Shared 32x32 multiplier step for the hex-float unit: one partial product a
// cycle while en is high, accumulated into a 128-bit product register. Depends on hfla_pkg.
`default_nettype none
module hfla_mul_step (
    input  wire logic         clk,
    input  wire logic         clear,
    input  wire logic         en,
    input  wire logic [1:0]   sel,
    input  wire logic [63:0]  x,
    input  wire logic [63:0]  y,
    output logic      [127:0] prod
);
    import hfla_pkg::*;

    logic [127:0] prod_reg;
    logic [31:0]  xh;
    logic [31:0]  yh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // choose halves, sel = {x half, y half}
    always_comb
    begin
        xh = sel[1] ? x[63:32] : x[31:0];
        yh = sel[0] ? y[63:32] : y[31:0];
        pp = xh * yh;
        pp_sh = {64'd0, pp} << (7'(sel[1]) * 7'd32 + 7'(sel[0]) * 7'd32);
    end

    always_ff @(posedge clk)
    begin
        if (clear)
            prod_reg <= '0;
        else if (en)
            prod_reg <= prod_reg + pp_sh;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

@@ rtl/hex_float_long_arith_unit.sv @@
// Top level of the hex-float long arithmetic unit: sequencer, one shared
// shifter/adder datapath, multiplier step. Depends on hfla_pkg, hfla_mul_step.
// Divide takes 4 quotient bits a cycle, normalization one hex digit a cycle.
// busy is high from acceptance until the done strobe; one item at a time, the next
// item is accepted at the edge that ends done. rst_n clears the sequencer and strobe;
// datapath registers are not reset.
`default_nettype none
module hex_float_long_arith_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire hfla_pkg::in_item_t  in_item,
    output logic                     busy,
    output logic                     done,
    output hfla_pkg::out_item_t      out_item
);
    import hfla_pkg::*;

    state_t       state_reg, state_next;
    logic [2:0]   op_reg;
    logic         sa_reg, sb_reg;
    logic [7:0]   ea_reg, eb_reg;          // signed working exponents (wrap ok)
    logic [63:0]  fa_reg, fb_reg;
    logic [63:0]  rm_reg;
    logic         rs_reg;
    logic [7:0]   re_reg;
    logic [3:0]   cnt_reg;
    logic [1:0]   msel_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         done_reg;
    out_item_t    out_reg;
    logic [127:0] prod;
    logic         mclear, men;

    logic         early_done;
    out_item_t    early_res;
    logic [63:0]  fa_nx, fb_nx, rm_nx, rem_nx, q_nx;
    logic [7:0]   ea_nx, eb_nx, re_nx;
    logic         sa_nx, rs_nx;
    logic [3:0]   cnt_nx;
    logic [1:0]   msel_nx;

    hfla_mul_step u_mul (
        .clk  (clk),
        .clear(mclear),
        .en   (men),
        .sel  (msel_reg),
        .x    (fa_reg),
        .y    (fb_reg),
        .prod (prod)
    );

    // helpers: packing
    function automatic logic [63:0] pack(input logic s, input logic [7:0] e,
                                         input logic [63:0] f);
        pack = {s, e[6:0], f[55:0]};
    endfunction

    // datapath and sequencer: one step per cycle
    logic [63:0] t64;
    logic [64:0] diff;
    logic [3:0]  qd;
    logic [67:0] r4;
    logic [67:0] rtry;
    logic [7:0]  shd;
    logic [63:0] shifted;
    logic [63:0] prhi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                        state_reg <= ST_NORMA;
                end
                ST_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= state_next;
            endcase
        end
    end

    // payload / working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_reg  <= in_item.operation;
                    sa_reg  <= in_item.operand_a[63];
                    sb_reg  <= in_item.operand_b[63];
                    ea_reg  <= {1'b0, in_item.operand_a[62:56]};
                    eb_reg  <= {1'b0, in_item.operand_b[62:56]};
                    fa_reg  <= {8'd0, in_item.operand_a[55:0]};
                    fb_reg  <= {8'd0, in_item.operand_b[55:0]};
                    if (in_item.operation == OP_CVT)
                    begin
                        sa_reg <= in_item.int_value[31];
                        fa_reg <= {8'd0, (in_item.int_value[31] ?
                                  32'(-in_item.int_value) : 32'(in_item.int_value)), 24'd0};
                        ea_reg <= 8'd68;
                    end
                    cnt_reg  <= '0;
                    msel_reg <= '0;
                end
            end
            default:
            begin
                fa_reg  <= fa_nx;  fb_reg <= fb_nx;
                ea_reg  <= ea_nx;  eb_reg <= eb_nx;
                sa_reg  <= sa_nx;
                rm_reg  <= rm_nx;  rs_reg <= rs_nx;
                re_reg  <= re_nx;
                cnt_reg <= cnt_nx; msel_reg <= msel_nx;
                rem_reg <= rem_nx; q_reg <= q_nx;
                if (early_done)
                    out_reg <= early_res;
            end
        endcase
    end

    wire za = (fa_reg[55:0] == 56'd0);
    wire zb = (fb_reg[55:0] == 56'd0);
    wire is_add = (op_reg == OP_ADD) || (op_reg == OP_SUB);
    wire sbe = sb_reg ^ (op_reg == OP_SUB);

    // one step of the sequence, next state
    always_comb
    begin
        fa_nx = fa_reg; fb_nx = fb_reg; ea_nx = ea_reg; eb_nx = eb_reg;
        sa_nx = sa_reg; rm_nx = rm_reg; rs_nx = rs_reg; re_nx = re_reg;
        cnt_nx = cnt_reg; msel_nx = msel_reg; rem_nx = rem_reg; q_nx = q_reg;
        state_next = state_reg;
        early_done = 1'b0;
        early_res = '0;
        mclear = 1'b0; men = 1'b0;
        t64 = '0; diff = '0; qd = '0; r4 = '0; rtry = '0; shd = '0;
        shifted = '0; prhi = '0;
        case (state_reg)
            ST_NORMA:
            begin
                // special cases and operand A normalization
                if (op_reg > 3'(OP_CVT))
                begin
                    early_done = 1'b1; state_next = ST_DONE;
                end
                else if (op_reg == OP_CVT)
                begin
                    if (za) begin early_done = 1'b1; state_next = ST_DONE; end
                    else if (fa_reg[55:52] == 4'd0)
                    begin fa_nx = fa_reg << 4; ea_nx = ea_reg - 8'd1; end
                    else
                    begin
                        early_done = 1'b1; state_next = ST_DONE;
                        early_res.result_word = pack(sa_reg, ea_reg, fa_reg);
                    end
                end
                else if (is_add)
                begin
                    state_next = ST_ADDALIGN;
                    if (za && zb) begin early_done = 1'b1; state_next = ST_DONE; end
                    else if (za)
                    begin
                        early_done = 1'b1; state_next = ST_DONE;
                        early_res.result_word = pack(sbe, eb_reg, fb_reg);
                    end
                    else if (zb)
                    begin
                        early_done = 1'b1; state_next = ST_DONE;
                        early_res.result_word = pack(sa_reg, ea_reg, fa_reg);
                    end
                end
                else if (op_reg == OP_DIV && zb)
                begin
                    early_done = 1'b1; state_next = ST_DONE;
                    early_res.divide_by_zero = 1'b1;
                end
                else if (za || zb)
                begin
                    early_done = 1'b1; state_next = ST_DONE;
                end
                else if (fa_reg[55:52] == 4'd0)
                begin fa_nx = fa_reg << 4; ea_nx = ea_reg - 8'd1; end
                else state_next = ST_NORMB;
            end
            ST_NORMB:
            begin
                if (fb_reg[55:52] == 4'd0)
                begin fb_nx = fb_reg << 4; eb_nx = eb_reg - 8'd1; end
                else if (op_reg == OP_MULR)
                    state_next = ST_ROUND;
                else if (op_reg == OP_MULX)
                begin
                    mclear = 1'b1; msel_nx = '0; state_next = ST_MUL;
                end
                else
                begin
                    rem_nx = fa_reg; q_nx = '0; cnt_nx = '0;
                    state_next = ST_DIV;
                end
            end
            ST_ROUND:
            begin
                // round both operands to 31 bits, keep only the top 31
                t64 = fa_reg + 64'h100_0000;
                if (t64[56]) begin t64 = t64 >> 4; ea_nx = ea_reg + 8'd1; end
                fa_nx = {33'd0, t64[55:25]};
                shifted = fb_reg + 64'h100_0000;
                if (shifted[56]) begin shifted = shifted >> 4; eb_nx = eb_reg + 8'd1; end
                fb_nx = {33'd0, shifted[55:25]};
                mclear = 1'b1; msel_nx = '0; state_next = ST_MUL;
            end
            ST_MUL:
            begin
                men = 1'b1;
                msel_nx = msel_reg + 2'd1;
                if (msel_reg == 2'd3) state_next = ST_MULFIN;
            end
            ST_MULFIN:
            begin
                state_next = ST_DONE; early_done = 1'b1;
                re_nx = ea_reg + eb_reg;
                if (op_reg == OP_MULR)
                begin
                    t64 = prod[63:0] >> 6;
                    if (t64 == 0) early_res.result_word = '0;
                    else if (t64[55:52] != 4'd0)
                        early_res.result_word = pack(sa_reg ^ sb_reg,
                            ea_reg + eb_reg - 8'd64, t64);
                    else
                        early_res.result_word = pack(sa_reg ^ sb_reg,
                            ea_reg + eb_reg - 8'd65, prod[63:0] >> 2);
                end
                else
                begin
                    prhi = prod[111:48];
                    if (prhi[63:60] != 4'd0) t64 = {8'd0, prod[111:56]};
                    else t64 = {8'd0, prod[107:52]};
                    if (t64 == 0) early_res.result_word = '0;
                    else early_res.result_word = pack(sa_reg ^ sb_reg,
                        ea_reg + eb_reg - ((prhi[63:60] != 4'd0) ? 8'd64 : 8'd65), t64);
                end
            end
            ST_DIV:
            begin
                // 4 quotient bits a cycle; first step gives the integer digit,
                // 14 more give 56 fraction bits: q = fa/fb * 2^56
                r4 = {4'd0, rem_reg};
                for (int i = 0; i < 4; i++)
                begin
                    if (cnt_reg == 4'd0)
                    begin
                        rtry = r4 - ({4'd0, fb_reg} << (3 - i));
                        qd[3-i] = !rtry[67];
                        if (!rtry[67]) r4 = rtry;
                    end
                    else
                    begin
                        r4 = r4 << 1;
                        rtry = r4 - {4'd0, fb_reg};
                        qd[3-i] = !rtry[67];
                        if (!rtry[67]) r4 = rtry;
                    end
                end
                rem_nx = r4[63:0];
                if (cnt_reg == 4'd0) q_nx = {60'd0, qd};
                else q_nx = {q_reg[59:0], qd};
                cnt_nx = cnt_reg + 4'd1;
                if (cnt_reg == 4'd14) state_next = ST_DIVFIN;
            end
            ST_DIVFIN:
            begin
                re_nx = ea_reg - eb_reg + 8'd64;
                if (q_reg[59:56] != 4'd0) begin q_nx = q_reg >> 4; re_nx = re_nx + 8'd1; end
                state_next = ST_ADDNORM;
                rm_nx = (q_reg[59:56] != 4'd0) ? (q_reg >> 4) : q_reg;
                rs_nx = sa_reg ^ sb_reg;
                cnt_nx = 4'd0;
            end
            ST_ADDALIGN:
            begin
                rs_nx = 1'b0;
                if (ea_reg == eb_reg)
                begin fa_nx = fa_reg << 4; fb_nx = fb_reg << 4; state_next = ST_ADDOP; end
                else if (ea_reg < eb_reg)
                begin
                    shd = eb_reg - ea_reg - 8'd1;
                    shifted = (shd >= 8'(ShiftOut)) ? 64'd0 : (fa_reg >> {shd[3:0], 2'b00});
                    if (shd != 0 && shifted == 0)
                    begin
                        early_done = 1'b1; state_next = ST_DONE;
                        early_res.result_word = pack(sbe, eb_reg, fb_reg);
                    end
                    else
                    begin fa_nx = shifted; fb_nx = fb_reg << 4; ea_nx = eb_reg;
                        state_next = ST_ADDOP; end
                end
                else
                begin
                    shd = ea_reg - eb_reg - 8'd1;
                    shifted = (shd >= 8'(ShiftOut)) ? 64'd0 : (fb_reg >> {shd[3:0], 2'b00});
                    if (shd != 0 && shifted == 0)
                    begin
                        early_done = 1'b1; state_next = ST_DONE;
                        early_res.result_word = pack(sa_reg, ea_reg, fa_reg);
                    end
                    else
                    begin fb_nx = shifted; fa_nx = fa_reg << 4; state_next = ST_ADDOP; end
                end
            end
            ST_ADDOP:
            begin
                diff = {1'b0, fa_reg} - {1'b0, fb_reg};
                re_nx = ea_reg;
                state_next = ST_ADDNORM;
                if (sa_reg == sbe) begin rs_nx = sa_reg; t64 = fa_reg + fb_reg; end
                else if (diff == 0)
                begin early_done = 1'b1; state_next = ST_DONE; end
                else if (!diff[64]) begin rs_nx = sa_reg; t64 = diff[63:0]; end
                else begin rs_nx = sbe; t64 = fb_reg - fa_reg; end
                // first renormalize step (guard digit)
                if (t64[63:60] != 4'd0) begin rm_nx = t64 >> 8; re_nx = ea_reg + 8'd1; end
                else if (t64[59:56] != 4'd0) rm_nx = t64 >> 4;
                else begin rm_nx = t64; re_nx = ea_reg - 8'd1; end
            end
            ST_ADDNORM:
            begin
                if (rm_reg[55:0] == 56'd0)
                begin early_done = 1'b1; state_next = ST_DONE; end
                else if (rm_reg[55:52] == 4'd0)
                begin rm_nx = rm_reg << 4; re_nx = re_reg - 8'd1; end
                else
                begin
                    early_done = 1'b1; state_next = ST_DONE;
                    early_res.result_word = pack(rs_reg, re_reg, rm_reg);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = (state_reg != ST_IDLE);
        done     = done_reg;
        out_item = out_reg;
    end
endmodule
`default_nettype wire

@@ rtl/hfla_checker.sv @@
// Port-level checker for the hex-float unit, bound to the top level.
// Depends on hfla_pkg.
`default_nettype none
module hfla_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire hfla_pkg::out_item_t out_item
);
    import hfla_pkg::*;

    // accepted item makes the unit busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not set busy");

    // done strobe ends busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // flag only with zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_item.divide_by_zero) |-> (out_item.result_word == 64'd0))
        else $error("divide by zero with nonzero result");
endmodule

bind hex_float_long_arith_unit hfla_checker u_hfla_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .out_item(out_item)
);
`default_nettype wire
